// ===== hdl/implicit_list_first_fit_allocator_core_assert.svh =====
// Assertion macros for the first-fit heap allocator core.
// Clocked on aclk and disabled while aresetn is low; no other dependencies.
`ifndef IMPLICIT_LIST_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define IMPLICIT_LIST_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define ILFFA_CHECK(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// A condition that holds in the same cycle as its trigger.
`define ILFFA_CHECK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// A condition that holds in the cycle after its trigger.
`define ILFFA_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ilffa_pkg.sv =====
// Shared types, constants and the microprogram of the first-fit allocator.
// Used by ilffa_seq and the top level; depends on nothing else.
package ilffa_pkg;

    localparam int BYTES_W    = 16;
    localparam int OFF_W      = 17;
    localparam int NEED_W     = 13;
    localparam int TGT_W      = 13;
    localparam int GRAN_SHIFT = 4;
    localparam int RES_LO_W   = OFF_W - GRAN_SHIFT;

    // Header bytes plus one granule less one byte, so that a shift rounds up.
    localparam logic [OFF_W-1:0] NEED_BIAS = 17'd23;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_MG_TEST, S_MG_HDR, S_MG_USED, S_MG_SKIP, S_MG_INNER, S_MG_INCHK, S_MG_ACC,
        S_MG_WRITE,
        S_FF_START, S_FF_TEST, S_FF_HDR, S_FF_FIT, S_FF_NEXT, S_FF_TAKE, S_FF_SPLIT,
        S_FF_WHEAD,
        S_AP_CHK, S_AP_WRITE,
        S_FR_CHK, S_FR_TEST, S_FR_HDR, S_FR_CMP, S_FR_NEXT, S_FR_REL, S_FR_WR,
        S_EM_OK, S_EM_OOM, S_EM_ZERO
    } step_t;

    typedef enum logic [3:0] {
        C_ALWAYS, C_ACCEPT, C_OP_FREE, C_PTR_LT_TOP, C_NXT_LT_TOP, C_SZ_ZERO, C_USED,
        C_FREE_NZ, C_FIT, C_EXACT, C_ROOM, C_TGT_OK, C_FR_WALK, C_PTR_EQ_TGT, C_OUT_FREE
    } cond_t;

    typedef enum logic [1:0] {RD_NONE, RD_PTR, RD_NXT} rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE, WR_MERGE, WR_SPLIT, WR_TAKE, WR_APPEND, WR_RELEASE
    } wr_sel_t;

    typedef enum logic [2:0] {P_HOLD, P_ZERO, P_NXT, P_ADV, P_TOP} ptr_op_t;
    typedef enum logic [1:0] {N_HOLD, N_START, N_ADV} nxt_op_t;
    typedef enum logic [1:0] {T_HOLD, T_LOAD, T_ADD} tot_op_t;
    typedef enum logic [1:0] {E_NONE, E_OK, E_OOM, E_ZERO} emit_t;

    typedef struct packed {
        cond_t   cond;
        step_t   jt;
        step_t   jf;
        logic    load_in;
        rd_sel_t rd;
        wr_sel_t wr;
        ptr_op_t ptr_op;
        nxt_op_t nxt_op;
        tot_op_t tot_op;
        logic    grow;
        emit_t   emit;
    } ctl_t;

    typedef struct packed {
        logic accept;
        logic op_free;
        logic ptr_lt_top;
        logic nxt_lt_top;
        logic sz_zero;
        logic used;
        logic free_nz;
        logic fit;
        logic exact;
        logic room;
        logic tgt_ok;
        logic fr_walk;
        logic ptr_eq_tgt;
        logic out_free;
    } flags_t;

    // Control store: one word per step. A word jumps to jt when its condition
    // holds and to jf otherwise.
    function automatic ctl_t ucode(step_t s);
        ctl_t w;
        w = '{cond: C_ALWAYS, jt: S_IDLE, jf: S_IDLE, load_in: 1'b0, rd: RD_NONE,
              wr: WR_NONE, ptr_op: P_HOLD, nxt_op: N_HOLD, tot_op: T_HOLD,
              grow: 1'b0, emit: E_NONE};
        case (s)
            S_IDLE: begin
                w.cond = C_ACCEPT; w.jt = S_DISPATCH; w.jf = S_IDLE; w.load_in = 1'b1;
            end
            S_DISPATCH: begin
                w.cond = C_OP_FREE; w.jt = S_FR_CHK; w.jf = S_MG_TEST; w.ptr_op = P_ZERO;
            end
            S_MG_TEST: begin
                w.cond = C_PTR_LT_TOP; w.jt = S_MG_HDR; w.jf = S_FF_START; w.rd = RD_PTR;
            end
            S_MG_HDR: begin
                w.cond = C_SZ_ZERO; w.jt = S_FF_START; w.jf = S_MG_USED;
                w.tot_op = T_LOAD; w.nxt_op = N_START;
            end
            S_MG_USED: begin
                w.cond = C_USED; w.jt = S_MG_SKIP; w.jf = S_MG_INNER;
            end
            S_MG_SKIP: begin
                w.jt = S_MG_TEST; w.jf = S_MG_TEST; w.ptr_op = P_NXT;
            end
            S_MG_INNER: begin
                w.cond = C_NXT_LT_TOP; w.jt = S_MG_INCHK; w.jf = S_MG_WRITE; w.rd = RD_NXT;
            end
            S_MG_INCHK: begin
                w.cond = C_FREE_NZ; w.jt = S_MG_ACC; w.jf = S_MG_WRITE;
            end
            S_MG_ACC: begin
                w.jt = S_MG_INNER; w.jf = S_MG_INNER; w.tot_op = T_ADD; w.nxt_op = N_ADV;
            end
            S_MG_WRITE: begin
                w.jt = S_MG_TEST; w.jf = S_MG_TEST; w.wr = WR_MERGE; w.ptr_op = P_NXT;
            end
            S_FF_START: begin
                w.jt = S_FF_TEST; w.jf = S_FF_TEST; w.ptr_op = P_ZERO;
            end
            S_FF_TEST: begin
                w.cond = C_PTR_LT_TOP; w.jt = S_FF_HDR; w.jf = S_AP_CHK; w.rd = RD_PTR;
            end
            S_FF_HDR: begin
                w.cond = C_SZ_ZERO; w.jt = S_AP_CHK; w.jf = S_FF_FIT;
            end
            S_FF_FIT: begin
                w.cond = C_FIT; w.jt = S_FF_TAKE; w.jf = S_FF_NEXT;
            end
            S_FF_NEXT: begin
                w.jt = S_FF_TEST; w.jf = S_FF_TEST; w.ptr_op = P_ADV;
            end
            S_FF_TAKE: begin
                w.cond = C_EXACT; w.jt = S_FF_WHEAD; w.jf = S_FF_SPLIT;
            end
            S_FF_SPLIT: begin
                w.jt = S_FF_WHEAD; w.jf = S_FF_WHEAD; w.wr = WR_SPLIT;
            end
            S_FF_WHEAD: begin
                w.jt = S_EM_OK; w.jf = S_EM_OK; w.wr = WR_TAKE;
            end
            S_AP_CHK: begin
                w.cond = C_ROOM; w.jt = S_AP_WRITE; w.jf = S_EM_OOM;
            end
            S_AP_WRITE: begin
                w.jt = S_EM_OK; w.jf = S_EM_OK; w.wr = WR_APPEND; w.ptr_op = P_TOP;
                w.grow = 1'b1;
            end
            S_FR_CHK: begin
                w.cond = C_TGT_OK; w.jt = S_FR_TEST; w.jf = S_EM_ZERO;
            end
            S_FR_TEST: begin
                w.cond = C_FR_WALK; w.jt = S_FR_HDR; w.jf = S_EM_ZERO; w.rd = RD_PTR;
            end
            S_FR_HDR: begin
                w.cond = C_SZ_ZERO; w.jt = S_EM_ZERO; w.jf = S_FR_CMP;
            end
            S_FR_CMP: begin
                w.cond = C_PTR_EQ_TGT; w.jt = S_FR_REL; w.jf = S_FR_NEXT;
            end
            S_FR_NEXT: begin
                w.jt = S_FR_TEST; w.jf = S_FR_TEST; w.ptr_op = P_ADV;
            end
            S_FR_REL: begin
                w.cond = C_USED; w.jt = S_FR_WR; w.jf = S_EM_ZERO;
            end
            S_FR_WR: begin
                w.jt = S_EM_ZERO; w.jf = S_EM_ZERO; w.wr = WR_RELEASE;
            end
            S_EM_OK: begin
                w.cond = C_OUT_FREE; w.jt = S_IDLE; w.jf = S_EM_OK; w.emit = E_OK;
            end
            S_EM_OOM: begin
                w.cond = C_OUT_FREE; w.jt = S_IDLE; w.jf = S_EM_OOM; w.emit = E_OOM;
            end
            S_EM_ZERO: begin
                w.cond = C_OUT_FREE; w.jt = S_IDLE; w.jf = S_EM_ZERO; w.emit = E_ZERO;
            end
            default: begin
                w.jt = S_IDLE; w.jf = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/implicit_list_first_fit_allocator_core.sv =====
// Top level of the first-fit heap allocator over an implicit block list.
// Depends on ilffa_pkg, ilffa_seq, ilffa_hdr_ram and the assertion header.
//
//   Channel  Direction  Handshake          Word
//   s_       in         s_valid / s_ready  s_operation, s_request_bytes, s_payload_offset
//   m_       out        m_valid / m_ready  m_status, m_result_offset
//
// One request is worked at a time. A free walks the block list up to the target.
// An allocate first runs a merge pass over the block heads, which merges the free
// blocks that follow each free block into it, then a first-fit pass that takes the
// first free block that fits, splitting off its remainder when it is larger, or
// else appends a block at the heap top if there is room. Every header access goes
// through the single read port of the header memory, which sets the step count.
// Reset puts the sequencer at idle and empties the heap; the header memory is
// not cleared, since only headers below the heap top are ever used.
// A stalled result word holds in the output register; a new request is taken
// once the sequencer is back at idle.
`include "implicit_list_first_fit_allocator_core_assert.svh"

module implicit_list_first_fit_allocator_core #(
    parameter int HEAP_GRANULES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [ilffa_pkg::BYTES_W-1:0] s_request_bytes,
    input  logic [ilffa_pkg::OFF_W-1:0]   s_payload_offset,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic [ilffa_pkg::OFF_W-1:0]   m_result_offset
);

    // GW holds a block size or the heap top, AW addresses a header.
    localparam int GW = $clog2(HEAP_GRANULES + 1);
    localparam int AW = $clog2(HEAP_GRANULES);
    localparam int HW = GW + 1;
    // Compare width: room for either a size or a need, plus a carry.
    localparam int CW = ((GW > ilffa_pkg::NEED_W) ? GW : ilffa_pkg::NEED_W) + 1;
    localparam logic [CW-1:0] HEAP_C = CW'(HEAP_GRANULES);

    // Sequencer interface.
    ilffa_pkg::ctl_t   ctl;
    ilffa_pkg::step_t  step;
    ilffa_pkg::flags_t flags;
    logic              hit;

    // Datapath registers.
    logic [GW-1:0]                 top_reg, top_next;
    logic [GW-1:0]                 ptr_reg, ptr_next;
    logic [GW-1:0]                 nxt_reg, nxt_next;
    logic [GW-1:0]                 total_reg, total_next;
    logic [ilffa_pkg::NEED_W-1:0]  need_reg;
    logic [ilffa_pkg::TGT_W-1:0]   tgt_reg;
    logic                          op_reg;
    logic                          tgt_ok_reg;
    logic                          m_valid_reg, m_valid_next;
    logic                          m_status_reg;
    logic [ilffa_pkg::OFF_W-1:0]   m_result_reg;

    // Request decode.
    logic [ilffa_pkg::OFF_W-1:0]   need_sum;
    logic [ilffa_pkg::NEED_W-1:0]  need_in;
    logic [ilffa_pkg::TGT_W-1:0]   tgt_in;
    logic                          off_ok;
    logic                          tgt_ok_in;

    // Header memory ports.
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [HW-1:0]   ram_wdata, ram_rdata;
    logic [GW-1:0]   wr_addr_g;

    // Fields of the header word just read.
    logic [GW-1:0]   rsize;
    logic            rused;

    // Extended views for comparison.
    logic [CW-1:0]   ptr_c, top_c, need_c, rsize_c, tgt_c, wr_addr_c, ptr_p1;
    logic [GW-1:0]   need_g;
    logic            out_load;

    ilffa_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctl     (ctl),
        .step    (step),
        .hit     (hit)
    );

    ilffa_hdr_ram #(
        .DEPTH (HEAP_GRANULES),
        .AW    (AW),
        .DW    (HW)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The granule count is (bytes + header + granule - 1) / granule, a shift.
    // A free target is the granule just below the payload offset; offsets that
    // are zero, not granule aligned, or target a granule at or above the top are ignored.
    always_comb begin
        need_sum  = ilffa_pkg::OFF_W'(s_request_bytes) + ilffa_pkg::NEED_BIAS;
        need_in   = need_sum[ilffa_pkg::OFF_W-1:ilffa_pkg::GRAN_SHIFT];
        off_ok    = (s_payload_offset != '0) &&
                    (s_payload_offset[ilffa_pkg::GRAN_SHIFT-1:0] == '0);
        tgt_in    = s_payload_offset[ilffa_pkg::OFF_W-1:ilffa_pkg::GRAN_SHIFT]
                    - ilffa_pkg::TGT_W'(1);
        tgt_ok_in = off_ok && (CW'(tgt_in) < CW'(top_reg));
    end

    always_comb begin
        rsize     = ram_rdata[HW-1:1];
        rused     = ram_rdata[0];
        ptr_c     = CW'(ptr_reg);
        top_c     = CW'(top_reg);
        need_c    = CW'(need_reg);
        need_g    = need_c[GW-1:0];
        rsize_c   = CW'(rsize);
        tgt_c     = CW'(tgt_reg);
        ptr_p1    = ptr_c + CW'(1);
    end

    // Branch conditions for the sequencer.
    always_comb begin
        flags.accept     = s_valid;
        flags.op_free    = op_reg;
        flags.ptr_lt_top = ptr_reg < top_reg;
        flags.nxt_lt_top = nxt_reg < top_reg;
        flags.sz_zero    = rsize == '0;
        flags.used       = rused;
        flags.free_nz    = !rused && (rsize != '0);
        flags.fit        = !rused && (rsize_c >= need_c);
        flags.exact      = rsize_c == need_c;
        flags.room       = (top_c + need_c) <= HEAP_C;
        flags.tgt_ok     = tgt_ok_reg;
        flags.fr_walk    = (ptr_reg < top_reg) && (ptr_c <= tgt_c);
        flags.ptr_eq_tgt = ptr_c == tgt_c;
        flags.out_free   = !m_valid_reg || m_ready;
    end

    // Header reads come from the walk pointer or the merge look-ahead pointer.
    always_comb begin
        ram_re    = ctl.rd != ilffa_pkg::RD_NONE;
        ram_raddr = (ctl.rd == ilffa_pkg::RD_NXT) ? nxt_reg[AW-1:0] : ptr_reg[AW-1:0];
    end

    // Header writes: a merged free block, the free remainder of a split, the
    // head of a taken block, a block appended at the top, or a released block.
    always_comb begin
        ram_we    = ctl.wr != ilffa_pkg::WR_NONE;
        wr_addr_g = ptr_reg;
        ram_wdata = {rsize, 1'b0};
        case (ctl.wr)
            ilffa_pkg::WR_MERGE: begin
                ram_wdata = {total_reg, 1'b0};
            end
            ilffa_pkg::WR_SPLIT: begin
                wr_addr_g = ptr_reg + need_g;
                ram_wdata = {rsize - need_g, 1'b0};
            end
            ilffa_pkg::WR_TAKE: begin
                ram_wdata = {need_g, 1'b1};
            end
            ilffa_pkg::WR_APPEND: begin
                wr_addr_g = top_reg;
                ram_wdata = {need_g, 1'b1};
            end
            ilffa_pkg::WR_RELEASE: begin
                ram_wdata = {rsize, 1'b0};
            end
            default: begin
                wr_addr_g = ptr_reg;
            end
        endcase
        ram_waddr = wr_addr_g[AW-1:0];
        wr_addr_c = CW'(wr_addr_g);
    end

    // Pointer and accumulator updates requested by the control word.
    always_comb begin
        case (ctl.ptr_op)
            ilffa_pkg::P_ZERO: ptr_next = '0;
            ilffa_pkg::P_NXT:  ptr_next = nxt_reg;
            ilffa_pkg::P_ADV:  ptr_next = ptr_reg + rsize;
            ilffa_pkg::P_TOP:  ptr_next = top_reg;
            default:           ptr_next = ptr_reg;
        endcase
        case (ctl.nxt_op)
            ilffa_pkg::N_START: nxt_next = ptr_reg + rsize;
            ilffa_pkg::N_ADV:   nxt_next = nxt_reg + rsize;
            default:            nxt_next = nxt_reg;
        endcase
        case (ctl.tot_op)
            ilffa_pkg::T_LOAD: total_next = rsize;
            ilffa_pkg::T_ADD:  total_next = total_reg + rsize;
            default:           total_next = total_reg;
        endcase
        top_next = ctl.grow ? (top_reg + need_g) : top_reg;
    end

    // The result word loads when an emit step finds the output register free.
    always_comb begin
        out_load     = (ctl.emit != ilffa_pkg::E_NONE) && hit;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            top_reg     <= top_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg   <= ptr_next;
        nxt_reg   <= nxt_next;
        total_reg <= total_next;
        if (ctl.load_in && s_valid) begin
            op_reg     <= s_operation;
            need_reg   <= need_in;
            tgt_reg    <= tgt_in;
            tgt_ok_reg <= tgt_ok_in;
        end
        if (out_load) begin
            case (ctl.emit)
                ilffa_pkg::E_OK: begin
                    m_status_reg <= 1'b0;
                    m_result_reg <= {ptr_p1[ilffa_pkg::RES_LO_W-1:0],
                                     ilffa_pkg::GRAN_SHIFT'(0)};
                end
                ilffa_pkg::E_OOM: begin
                    m_status_reg <= 1'b1;
                    m_result_reg <= '0;
                end
                default: begin
                    m_status_reg <= 1'b0;
                    m_result_reg <= '0;
                end
            endcase
        end
    end

    assign s_ready         = step == ilffa_pkg::S_IDLE;
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_result_offset = m_result_reg;

    // The heap never grows past its end.
    `ILFFA_CHECK(a_top_in_heap, top_c <= HEAP_C, "heap top is beyond the heap end")
    // Every header write other than an append lands inside the block list.
    `ILFFA_CHECK_IMPL(a_write_below_top, (ctl.wr != ilffa_pkg::WR_NONE) && (ctl.wr != ilffa_pkg::WR_APPEND), wr_addr_c < top_c, "header write above the heap top")
    // An accepted request takes the sequencer out of idle.
    `ILFFA_CHECK_NEXT(a_accept_leaves_idle, s_valid && s_ready, !s_ready, "sequencer stayed idle after a request")

endmodule

// ===== hdl/ilffa_hdr_ram.sv =====
// Block header memory: one write port and one read port with registered data.
// Stand-alone; no package needed.
module ilffa_hdr_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 14
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ilffa_seq.sv =====
// Microprogram sequencer: step counter, control store lookup and branch select.
// Depends on ilffa_pkg for the step, condition and control word types.
module ilffa_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ilffa_pkg::flags_t     flags,
    output ilffa_pkg::ctl_t       ctl,
    output ilffa_pkg::step_t      step,
    output logic                  hit
);

    ilffa_pkg::step_t pc_reg;
    ilffa_pkg::step_t pc_next;

    always_comb begin
        ctl = ilffa_pkg::ucode(pc_reg);
        case (ctl.cond)
            ilffa_pkg::C_ALWAYS:     hit = 1'b1;
            ilffa_pkg::C_ACCEPT:     hit = flags.accept;
            ilffa_pkg::C_OP_FREE:    hit = flags.op_free;
            ilffa_pkg::C_PTR_LT_TOP: hit = flags.ptr_lt_top;
            ilffa_pkg::C_NXT_LT_TOP: hit = flags.nxt_lt_top;
            ilffa_pkg::C_SZ_ZERO:    hit = flags.sz_zero;
            ilffa_pkg::C_USED:       hit = flags.used;
            ilffa_pkg::C_FREE_NZ:    hit = flags.free_nz;
            ilffa_pkg::C_FIT:        hit = flags.fit;
            ilffa_pkg::C_EXACT:      hit = flags.exact;
            ilffa_pkg::C_ROOM:       hit = flags.room;
            ilffa_pkg::C_TGT_OK:     hit = flags.tgt_ok;
            ilffa_pkg::C_FR_WALK:    hit = flags.fr_walk;
            ilffa_pkg::C_PTR_EQ_TGT: hit = flags.ptr_eq_tgt;
            ilffa_pkg::C_OUT_FREE:   hit = flags.out_free;
            default:                 hit = 1'b0;
        endcase
        pc_next = hit ? ctl.jt : ctl.jf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ilffa_pkg::S_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign step = pc_reg;

endmodule
